// File: hw/rtl/rbf_pkg.sv
// Shared types and constants for the ring buffer FIFO with peek.
package rbf_pkg;

  localparam int OPC_W  = 3;
  localparam int DATA_W = 32;
  localparam int AMT_W  = 10;
  localparam int FILL_W = 10;
  localparam int CAP_W  = 11;
  localparam int APB_DW = 32;
  localparam int ADDR_W = 3;

  localparam logic [OPC_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OPC_W-1:0] OP_PULL  = 3'd1;
  localparam logic [OPC_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OPC_W-1:0] OP_ADV_W = 3'd3;
  localparam logic [OPC_W-1:0] OP_ADV_R = 3'd4;
  localparam logic [OPC_W-1:0] OP_CLEAR = 3'd5;

  localparam logic [CAP_W-1:0] CAP_RESET   = 11'd1024;
  localparam logic             REG_CAP_IDX = 1'b0;

  typedef struct packed {
    logic accept;
    logic mod_step;
    logic exec;
    logic load;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic mod_op;
    logic clr_done;
  } sts_t;

endpackage

// File: hw/rtl/rbf_in_if.sv
// Request channel carrying one FIFO operation.
interface rbf_in_if;
  logic                       valid;
  logic                       ready;
  logic [rbf_pkg::OPC_W-1:0]  opcode;
  logic [rbf_pkg::DATA_W-1:0] push_data;
  logic [rbf_pkg::AMT_W-1:0]  amount;

  modport source (output valid, opcode, push_data, amount, input ready);
  modport sink   (input valid, opcode, push_data, amount, output ready);
endinterface

// File: hw/rtl/rbf_out_if.sv
// Result channel carrying one FIFO operation outcome.
interface rbf_out_if;
  logic                       valid;
  logic                       ready;
  logic [rbf_pkg::DATA_W-1:0] data_out;
  logic                       ok;
  logic [rbf_pkg::FILL_W-1:0] fill_level;
  logic [rbf_pkg::FILL_W-1:0] free_space;
  logic                       overflow;

  modport source (output valid, data_out, ok, fill_level, free_space, overflow, input ready);
  modport sink   (input valid, data_out, ok, fill_level, free_space, overflow, output ready);
endinterface

// File: hw/rtl/ring_buffer_fifo_with_peek.sv
// Top level of the ring buffer FIFO with peek.
// Sequence: a request is accepted in idle, passes the execute and response states, and its
//   result is registered when the output is free; peek and pointer advances first run
//   10 remainder steps (amount mod capacity). Only one request is in flight at a time.
// Reset: synchronous, active low; a clearing pass then zeroes the store with in_req.ready low;
//   configuration writes are taken during the pass.
module ring_buffer_fifo_with_peek #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rbf_in_if.sink                     in_req,
  rbf_out_if.source                  out_res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbf_pkg::ADDR_W-1:0] paddr,
  input  logic [rbf_pkg::APB_DW-1:0] pwdata,
  output logic [rbf_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  localparam int CW = $clog2(DEPTH) + 1;

  rbf_pkg::cmd_t cmd;
  rbf_pkg::sts_t sts;
  logic [CW-1:0] cap;
  logic          cfg_wr;

  rbf_regs #(.DEPTH(DEPTH), .CW(CW)) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cap_o    (cap),
    .cfg_wr_o (cfg_wr)
  );

  rbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rbf_dp #(.DEPTH(DEPTH), .WIDTH(WIDTH), .CW(CW)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (in_req.opcode),
    .push_data  (in_req.push_data),
    .amount     (in_req.amount),
    .cap_i      (cap),
    .cfg_wr_i   (cfg_wr),
    .data_out   (out_res.data_out),
    .ok         (out_res.ok),
    .fill_level (out_res.fill_level),
    .free_space (out_res.free_space),
    .overflow   (out_res.overflow)
  );

endmodule

// File: hw/rtl/rbf_regs.sv
// APB register block holding the capacity setting and its clamped value.
module rbf_regs #(
  parameter int DEPTH = 1024,
  parameter int CW    = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbf_pkg::ADDR_W-1:0]  paddr,
  input  logic [rbf_pkg::APB_DW-1:0]  pwdata,
  output logic [rbf_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [CW-1:0]               cap_o,
  output logic                        cfg_wr_o
);

  localparam int XW      = (CW > rbf_pkg::CAP_W) ? CW : rbf_pkg::CAP_W;
  localparam int EFF_RST = (1024 > DEPTH) ? DEPTH : 1024;

  logic [rbf_pkg::CAP_W-1:0] cap_r;
  logic [CW-1:0]             eff_r;
  logic [XW-1:0]             wr_ext;
  logic [XW-1:0]             wr_eff;
  logic                      hit;

  assign hit      = (paddr[rbf_pkg::ADDR_W-1] == rbf_pkg::REG_CAP_IDX);
  assign cfg_wr_o = psel && penable && pwrite && hit;
  assign pready   = 1'b1;
  assign cap_o    = eff_r;
  assign prdata   = hit ? rbf_pkg::APB_DW'(cap_r) : '0;

  always_comb begin
    wr_ext = XW'(pwdata[rbf_pkg::CAP_W-1:0]);
    if (wr_ext < XW'(2)) begin
      wr_eff = XW'(2);
    end else if (wr_ext > XW'(DEPTH)) begin
      wr_eff = XW'(DEPTH);
    end else begin
      wr_eff = wr_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= rbf_pkg::CAP_RESET;
      eff_r <= CW'(EFF_RST);
    end else if (cfg_wr_o) begin
      cap_r <= pwdata[rbf_pkg::CAP_W-1:0];
      eff_r <= CW'(wr_eff);
    end
  end

endmodule

// File: hw/rtl/rbf_ctrl.sv
// Sequencer for clearing pass, remainder steps, execute and result handoff.
module rbf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rbf_pkg::sts_t sts,
  output rbf_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;
  localparam int CNT_W = $clog2(rbf_pkg::AMT_W + 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_vld_r, out_vld_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = sts.mod_op ? S_MOD : S_EXEC;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(rbf_pkg::AMT_W - 1)) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_vld_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign out_valid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  a_mod_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |=> (state_r == S_MOD || state_r == S_EXEC))
    else $error("remainder loop left early");

endmodule

// File: hw/rtl/rbf_dp.sv
// Datapath: pointers, remainder unit, element store and result register.
module rbf_dp #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int CW    = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rbf_pkg::cmd_t               cmd,
  output rbf_pkg::sts_t               sts,
  input  logic [rbf_pkg::OPC_W-1:0]   opcode,
  input  logic [rbf_pkg::DATA_W-1:0]  push_data,
  input  logic [rbf_pkg::AMT_W-1:0]   amount,
  input  logic [CW-1:0]               cap_i,
  input  logic                        cfg_wr_i,
  output logic [rbf_pkg::DATA_W-1:0]  data_out,
  output logic                        ok,
  output logic [rbf_pkg::FILL_W-1:0]  fill_level,
  output logic [rbf_pkg::FILL_W-1:0]  free_space,
  output logic                        overflow
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] store_mem [DEPTH];

  logic [PW-1:0]                 rp_r, rp_nxt, wp_r, wp_nxt, clr_addr_r;
  logic                          ovf_r, ovf_nxt, ok_r, ok_nxt, dsel_r, dsel_nxt;
  logic [rbf_pkg::OPC_W-1:0]     op_r, op_nxt;
  logic [rbf_pkg::DATA_W-1:0]    data_r, data_nxt;
  logic [rbf_pkg::AMT_W-1:0]     sh_r, sh_nxt;
  logic [CW-1:0]                 rem_r, rem_nxt;
  logic [WIDTH-1:0]              rdata_r;
  logic [rbf_pkg::DATA_W-1:0]    dout_r;
  logic                          okout_r, ovfout_r;
  logic [rbf_pkg::FILL_W-1:0]    fillout_r, freeout_r;

  logic [CW-1:0]    fill, free, rp_w, wp_w;
  logic [CW:0]      trial, sum;
  logic [PW-1:0]    base, wrapped, wp_inc, rp_inc;
  logic             push_we, mem_we, mem_re;
  logic [PW-1:0]    mem_wa, mem_ra;
  logic [WIDTH-1:0] mem_wd;

  assign rp_w = CW'(rp_r);
  assign wp_w = CW'(wp_r);
  assign fill = (wp_w >= rp_w) ? (wp_w - rp_w) : (cap_i - rp_w + wp_w);
  assign free = cap_i - CW'(1) - fill;

  assign wp_inc = (wp_w + CW'(1) == cap_i) ? '0 : wp_r + PW'(1);
  assign rp_inc = (rp_w + CW'(1) == cap_i) ? '0 : rp_r + PW'(1);

  assign base    = (op_r == rbf_pkg::OP_ADV_W) ? wp_r : rp_r;
  assign sum     = {1'b0, CW'(base)} + {1'b0, rem_r};
  assign wrapped = (sum >= {1'b0, cap_i}) ? PW'(sum - {1'b0, cap_i}) : PW'(sum);
  assign trial   = {rem_r, sh_r[rbf_pkg::AMT_W-1]};

  assign sts.mod_op   = (opcode inside {rbf_pkg::OP_PEEK, rbf_pkg::OP_ADV_W,
                                        rbf_pkg::OP_ADV_R});
  assign sts.clr_done = (clr_addr_r == PW'(DEPTH - 1));

  always_comb begin
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    ovf_nxt  = ovf_r;
    ok_nxt   = ok_r;
    dsel_nxt = dsel_r;
    op_nxt   = op_r;
    data_nxt = data_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    push_we  = 1'b0;
    mem_re   = 1'b0;
    mem_ra   = rp_r;
    if (cmd.accept) begin
      op_nxt   = opcode;
      data_nxt = push_data;
      sh_nxt   = amount;
      rem_nxt  = '0;
    end
    if (cmd.mod_step) begin
      sh_nxt = sh_r << 1;
      if (trial >= {1'b0, cap_i}) begin
        rem_nxt = CW'(trial - {1'b0, cap_i});
      end else begin
        rem_nxt = CW'(trial);
      end
    end
    if (cmd.exec) begin
      ok_nxt   = 1'b0;
      dsel_nxt = 1'b0;
      case (op_r)
        rbf_pkg::OP_PUSH: begin
          if (fill < cap_i - CW'(1)) begin
            push_we = 1'b1;
            wp_nxt  = wp_inc;
            ok_nxt  = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        rbf_pkg::OP_PULL: begin
          if (rp_r != wp_r) begin
            mem_re   = 1'b1;
            rp_nxt   = rp_inc;
            ok_nxt   = 1'b1;
            dsel_nxt = 1'b1;
          end
        end
        rbf_pkg::OP_PEEK: begin
          mem_re   = 1'b1;
          mem_ra   = wrapped;
          dsel_nxt = 1'b1;
        end
        rbf_pkg::OP_ADV_W: wp_nxt = wrapped;
        rbf_pkg::OP_ADV_R: rp_nxt = wrapped;
        rbf_pkg::OP_CLEAR: begin
          rp_nxt  = '0;
          wp_nxt  = '0;
          ovf_nxt = 1'b0;
        end
        default: ;
      endcase
    end
    if (cfg_wr_i) begin
      rp_nxt = '0;
      wp_nxt = '0;
    end
  end

  assign mem_we = cmd.clr_step || push_we;
  assign mem_wa = cmd.clr_step ? clr_addr_r : wp_r;
  assign mem_wd = cmd.clr_step ? '0 : WIDTH'(data_r);

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= store_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r       <= '0;
      wp_r       <= '0;
      ovf_r      <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      rp_r  <= rp_nxt;
      wp_r  <= wp_nxt;
      ovf_r <= ovf_nxt;
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    dsel_r <= dsel_nxt;
    op_r   <= op_nxt;
    data_r <= data_nxt;
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    if (cmd.load) begin
      dout_r    <= dsel_r ? rbf_pkg::DATA_W'(rdata_r) : '0;
      okout_r   <= ok_r;
      fillout_r <= rbf_pkg::FILL_W'(fill);
      freeout_r <= rbf_pkg::FILL_W'(free);
      ovfout_r  <= ovf_r;
    end
  end

  assign data_out   = dout_r;
  assign ok         = okout_r;
  assign fill_level = fillout_r;
  assign free_space = freeout_r;
  assign overflow   = ovfout_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_w < cap_i) && (rp_w < cap_i))
    else $error("pointer outside capacity");

  a_ovf_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> ($past(cmd.exec) && $past(op_r) == rbf_pkg::OP_PUSH))
    else $error("overflow set without refused push");

endmodule
